[rtl/rdi_pkg.sv]
package rdi_pkg;

  // Fixed point and pipeline sizing
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int CORDIC_STEPS      = 24;
  localparam int NORM_TOP          = 40;
  localparam int CORDIC_XW         = 44;
  localparam int CORDIC_ZW         = 34;
  localparam int T_QW              = 31;
  localparam int PART_QW           = 17;
  localparam int SQRT_STEPS        = 32;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DISK_HEIGHT  = 2'd0,
    REG_OUTER_RADIUS = 2'd1,
    REG_INNER_RADIUS = 2'd2,
    REG_PHI_LIMIT    = 2'd3
  } reg_index_t;

  // Ray data carried alongside the t divider
  typedef struct packed {
    logic               miss;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } front_t;

  // Hit data carried through the back end of the pipeline
  typedef struct packed {
    logic               miss;
    logic               zero_pt;
    logic [30:0]        t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [30:0]        ax;
    logic [30:0]        ay;
    logic [62:0]        d2;
    logic [16:0]        code;
    logic [16:0]        u;
  } item_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

[rtl/rdi_div.sv]
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// Expects num < den * 2^QW; sideband data travels with each transaction.
module rdi_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int RW = DW + QW;

  logic          vld [QW];
  logic [RW-1:0] rem [QW];
  logic [DW-1:0] dv  [QW];
  logic [QW-1:0] qv  [QW];
  logic [SW-1:0] sb  [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic          vi;
    logic [RW-1:0] ri;
    logic [RW-1:0] sh;
    logic [RW-1:0] ro;
    logic [DW-1:0] di;
    logic [QW-1:0] qi;
    logic [QW-1:0] qo;
    logic [SW-1:0] si;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ri = RW'(num);
      assign di = den;
      assign qi = '0;
      assign si = side_in;
    end else begin : g_next
      assign vi = vld[k-1];
      assign ri = rem[k-1];
      assign di = dv[k-1];
      assign qi = qv[k-1];
      assign si = sb[k-1];
    end

    // Try to subtract the shifted divisor, set the quotient bit on success
    always_comb begin
      sh = RW'(di) << (QW - 1 - k);
      ro = ri;
      qo = qi;
      if (ri >= sh) begin
        ro = ri - sh;
        qo[QW-1-k] = 1'b1;
      end
    end

    // Advance one stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vi;
      end
      rem[k] <= ro;
      dv[k]  <= di;
      qv[k]  <= qo;
      sb[k]  <= si;
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = qv[QW-1];
  assign side_out  = sb[QW-1];

endmodule

[rtl/rdi_cordic.sv]
// Vectoring CORDIC, one micro-rotation per stage; angle in 2^-32 turn.
module rdi_cordic #(
  parameter int SW = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [rdi_pkg::CORDIC_XW-1:0] x_in,
  input  logic signed [rdi_pkg::CORDIC_XW-1:0] y_in,
  input  logic [SW-1:0]                       side_in,
  output logic                                out_valid,
  output logic signed [rdi_pkg::CORDIC_ZW-1:0] z_out,
  output logic [SW-1:0]                       side_out
);

  localparam int N  = rdi_pkg::CORDIC_STEPS;
  localparam int XW = rdi_pkg::CORDIC_XW;
  localparam int ZW = rdi_pkg::CORDIC_ZW;

  logic                 vld [N];
  logic signed [XW-1:0] xs  [N];
  logic signed [XW-1:0] ys  [N];
  logic signed [ZW-1:0] zs  [N];
  logic [SW-1:0]        sb  [N];

  genvar i;
  for (i = 0; i < N; i++) begin : g_step
    logic                 vi;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic [SW-1:0]        si;
    logic signed [XW-1:0] xo;
    logic signed [XW-1:0] yo;
    logic signed [ZW-1:0] zo;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = x_in;
      assign yi = y_in;
      assign zi = '0;
      assign si = side_in;
    end else begin : g_next
      assign vi = vld[i-1];
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign si = sb[i-1];
    end

    assign ang = $signed({2'b00, rdi_pkg::atan_turn(i)});

    // Rotate toward the x axis
    always_comb begin
      if (!yi[XW-1]) begin
        xo = xi + (yi >>> i);
        yo = yi - (xi >>> i);
        zo = zi + ang;
      end else begin
        xo = xi - (yi >>> i);
        yo = yi + (xi >>> i);
        zo = zi - ang;
      end
    end

    // Advance one step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vi;
      end
      xs[i] <= xo;
      ys[i] <= yo;
      zs[i] <= zo;
      sb[i] <= si;
    end
  end

  assign out_valid = vld[N-1];
  assign z_out     = zs[N-1];
  assign side_out  = sb[N-1];

endmodule

[rtl/ray_disk_intersect.sv]
// Ray against partial annulus in the plane z = disk_height, fixed point with FRAC_BITS
// fraction bits. One ray is taken in every cycle (busy stays low) and its result shows
// as a one-cycle done strobe with hit and the hit fields; the receiver cannot stall,
// so results must be taken when done is high. The latency is set by the 31-stage
// divider for t, the 24-step CORDIC for the angle, the 32-stage square root and the
// two 17-stage dividers for u and v, plus fourteen stages of multiply, add and compare.
// Write configuration only when no ray is in flight.
module ray_disk_intersect #(
  parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] org_x,
  input  logic signed [31:0] org_y,
  input  logic signed [31:0] org_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        t_limit,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  output logic               done,
  output logic               hit,
  output logic [30:0]        t_hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic [15:0]        param_u,
  output logic [15:0]        param_v
);

  localparam int UNW = 33 + FRAC_BITS;
  localparam int NQ  = rdi_pkg::SQRT_STEPS;
  localparam int LAT = 3 + rdi_pkg::T_QW + 6 + 2 + rdi_pkg::CORDIC_STEPS + 1
                       + rdi_pkg::PART_QW + NQ + 1 + rdi_pkg::PART_QW + 1;

  // Configuration registers
  logic signed [31:0] disk_height;
  logic [30:0]        outer_radius;
  logic [30:0]        inner_radius;
  logic [16:0]        phi_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_height  <= '0;
      outer_radius <= 31'd1 << FRAC_BITS;
      inner_radius <= '0;
      phi_limit    <= 17'd65536;
    end else if (wr_en) begin
      case (rdi_pkg::reg_index_t'(wr_index))
        rdi_pkg::REG_DISK_HEIGHT:  disk_height  <= wr_data;
        rdi_pkg::REG_OUTER_RADIUS: outer_radius <= wr_data[30:0];
        rdi_pkg::REG_INNER_RADIUS: inner_radius <= wr_data[30:0];
        rdi_pkg::REG_PHI_LIMIT:    phi_limit    <= wr_data[16:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: plane distance and direction checks
  logic signed [32:0] num_c;
  logic               s1_valid;
  logic signed [32:0] s1_num;
  logic [31:0]        s1_ud;
  logic               s1_bad;
  logic [30:0]        s1_tmax;
  rdi_pkg::front_t    s1_front;

  assign num_c = {disk_height[31], disk_height} - {org_z[31], org_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_num   <= num_c;
    s1_ud    <= dir_z[31] ? 32'(-dir_z) : dir_z;
    s1_bad   <= (dir_z == '0) || (num_c == '0) || (num_c[32] != dir_z[31]);
    s1_tmax  <= t_limit;
    s1_front <= '{miss: 1'b0, ox: org_x, oy: org_y, dx: dir_x, dy: dir_y};
  end

  // Stage 2: scale numerator, form t limit bound
  logic [32:0]     mag_num;
  logic            s2_valid;
  logic [UNW-1:0]  s2_un;
  logic [62:0]     s2_prod;
  logic [31:0]     s2_ud;
  logic            s2_bad;
  rdi_pkg::front_t s2_front;

  assign mag_num = s1_num[32] ? 33'(-s1_num) : 33'(s1_num);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_un    <= UNW'(mag_num) << FRAC_BITS;
    s2_prod  <= 63'(s1_tmax) * 63'(s1_ud);
    s2_ud    <= s1_ud;
    s2_bad   <= s1_bad;
    s2_front <= s1_front;
  end

  // Stage 3: drop rays at or beyond t_limit
  logic            s3_valid;
  logic [UNW-1:0]  s3_un;
  logic [31:0]     s3_ud;
  rdi_pkg::front_t s3_front;
  rdi_pkg::front_t s3_front_next;

  always_comb begin
    s3_front_next      = s2_front;
    s3_front_next.miss = s2_bad || (63'(s2_un) >= s2_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_un    <= s2_un;
    s3_ud    <= s2_ud;
    s3_front <= s3_front_next;
  end

  // t = un / ud
  logic            tq_valid;
  logic [30:0]     tq;
  rdi_pkg::front_t tq_front;

  rdi_div #(
    .NW(UNW), .DW(32), .QW(rdi_pkg::T_QW), .SW($bits(rdi_pkg::front_t))
  ) u_div_t (
    .clk(clk), .rst(rst), .in_valid(s3_valid), .num(s3_un), .den(s3_ud),
    .side_in(s3_front), .out_valid(tq_valid), .quo(tq), .side_out(tq_front)
  );

  // Stage A: direction times t
  logic               sa_valid;
  logic signed [63:0] sa_px;
  logic signed [63:0] sa_py;
  logic signed [31:0] sa_ox;
  logic signed [31:0] sa_oy;
  logic [30:0]        sa_t;
  logic               sa_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else begin
      sa_valid <= tq_valid;
    end
    sa_px   <= tq_front.dx * $signed({1'b0, tq});
    sa_py   <= tq_front.dy * $signed({1'b0, tq});
    sa_ox   <= tq_front.ox;
    sa_oy   <= tq_front.oy;
    sa_t    <= tq;
    sa_miss <= tq_front.miss;
  end

  // Round product to nearest, halves away from zero, and add origin
  function automatic logic signed [63:0] along(input logic signed [31:0] o,
                                               input logic signed [63:0] p);
    logic [63:0]        mag;
    logic [63:0]        q;
    logic signed [63:0] oe;
    mag = p[63] ? 64'(-p) : 64'(p);
    q   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    oe  = {{32{o[31]}}, o};
    return p[63] ? (oe - $signed(q)) : (oe + $signed(q));
  endfunction

  // Stage B: hit point
  logic               sb_valid;
  logic signed [63:0] sb_px;
  logic signed [63:0] sb_py;
  logic [30:0]        sb_t;
  logic               sb_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else begin
      sb_valid <= sa_valid;
    end
    sb_px   <= along(sa_ox, sa_px);
    sb_py   <= along(sa_oy, sa_py);
    sb_t    <= sa_t;
    sb_miss <= sa_miss;
  end

  // Stage C: drop far hit points, take magnitudes
  logic        fit_x;
  logic        fit_y;
  logic [31:0] neg_x;
  logic [31:0] neg_y;
  logic        sc_valid;
  rdi_pkg::item_t sc_item;
  rdi_pkg::item_t sc_item_next;

  assign fit_x = (sb_px[63:31] == '0) || ((sb_px[63:31] == '1) && (sb_px[30:0] != '0));
  assign fit_y = (sb_py[63:31] == '0) || ((sb_py[63:31] == '1) && (sb_py[30:0] != '0));
  assign neg_x = 32'd0 - sb_px[31:0];
  assign neg_y = 32'd0 - sb_py[31:0];

  always_comb begin
    sc_item_next      = '0;
    sc_item_next.miss = sb_miss || !fit_x || !fit_y;
    sc_item_next.t    = sb_t;
    sc_item_next.px   = sb_px[31:0];
    sc_item_next.py   = sb_py[31:0];
    sc_item_next.ax   = sb_px[31] ? neg_x[30:0] : sb_px[30:0];
    sc_item_next.ay   = sb_py[31] ? neg_y[30:0] : sb_py[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else begin
      sc_valid <= sb_valid;
    end
    sc_item <= sc_item_next;
  end

  // Stage D: squares
  logic           sd_valid;
  logic [61:0]    sd_sqx;
  logic [61:0]    sd_sqy;
  logic [61:0]    sd_ro2;
  logic [61:0]    sd_ri2;
  rdi_pkg::item_t sd_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else begin
      sd_valid <= sc_valid;
    end
    sd_sqx  <= 62'(sc_item.ax) * 62'(sc_item.ax);
    sd_sqy  <= 62'(sc_item.ay) * 62'(sc_item.ay);
    sd_ro2  <= 62'(outer_radius) * 62'(outer_radius);
    sd_ri2  <= 62'(inner_radius) * 62'(inner_radius);
    sd_item <= sc_item;
  end

  // Stage E: squared radius
  logic           se_valid;
  logic [61:0]    se_ro2;
  logic [61:0]    se_ri2;
  rdi_pkg::item_t se_item;
  rdi_pkg::item_t se_item_next;

  always_comb begin
    se_item_next    = sd_item;
    se_item_next.d2 = 63'(sd_sqx) + 63'(sd_sqy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      se_valid <= 1'b0;
    end else begin
      se_valid <= sd_valid;
    end
    se_ro2  <= sd_ro2;
    se_ri2  <= sd_ri2;
    se_item <= se_item_next;
  end

  // Stage F: radial range test
  logic           sf_valid;
  rdi_pkg::item_t sf_item;
  rdi_pkg::item_t sf_item_next;

  always_comb begin
    sf_item_next      = se_item;
    sf_item_next.miss = se_item.miss || (se_item.d2 > 63'(se_ro2))
                        || (se_item.d2 < 63'(se_ri2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_valid <= 1'b0;
    end else begin
      sf_valid <= se_valid;
    end
    sf_item <= sf_item_next;
  end

  // Stage L: leading one of the larger magnitude
  logic [30:0]    big;
  logic [5:0]     top_bit;
  logic           sl_valid;
  logic [5:0]     sl_shift;
  rdi_pkg::item_t sl_item;
  rdi_pkg::item_t sl_item_next;

  always_comb begin
    big     = (sf_item.ax > sf_item.ay) ? sf_item.ax : sf_item.ay;
    top_bit = '0;
    for (int i = 0; i < 31; i++) begin
      if (big[i]) begin
        top_bit = 6'(i);
      end
    end
    sl_item_next         = sf_item;
    sl_item_next.zero_pt = (big == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sl_valid <= 1'b0;
    end else begin
      sl_valid <= sf_valid;
    end
    sl_shift <= 6'(rdi_pkg::NORM_TOP) - top_bit;
    sl_item  <= sl_item_next;
  end

  // Stage S: normalize for the CORDIC
  logic                                 ss_valid;
  logic signed [rdi_pkg::CORDIC_XW-1:0] ss_x;
  logic signed [rdi_pkg::CORDIC_XW-1:0] ss_y;
  rdi_pkg::item_t                       ss_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      ss_valid <= 1'b0;
    end else begin
      ss_valid <= sl_valid;
    end
    ss_x    <= $signed(rdi_pkg::CORDIC_XW'(sl_item.ax) << sl_shift);
    ss_y    <= $signed(rdi_pkg::CORDIC_XW'(sl_item.ay) << sl_shift);
    ss_item <= sl_item;
  end

  // First quadrant angle
  logic                                 cz_valid;
  logic signed [rdi_pkg::CORDIC_ZW-1:0] cz;
  rdi_pkg::item_t                       cz_item;

  rdi_cordic #(
    .SW($bits(rdi_pkg::item_t))
  ) u_cordic (
    .clk(clk), .rst(rst), .in_valid(ss_valid), .x_in(ss_x), .y_in(ss_y),
    .side_in(ss_item), .out_valid(cz_valid), .z_out(cz), .side_out(cz_item)
  );

  // Stage Z: clamp, place in quadrant, round to 1/65536 turn, test sweep
  logic [30:0] th;
  logic [32:0] phi;
  logic [32:0] phi_rnd;
  logic        sz_valid;
  rdi_pkg::item_t sz_item;
  rdi_pkg::item_t sz_item_next;

  always_comb begin
    if (cz[rdi_pkg::CORDIC_ZW-1]) begin
      th = '0;
    end else if (cz > $signed(rdi_pkg::CORDIC_ZW'(1) << 30)) begin
      th = 31'd1 << 30;
    end else begin
      th = cz[30:0];
    end
    if (cz_item.zero_pt) begin
      phi = '0;
    end else if (!cz_item.px[31] && !cz_item.py[31]) begin
      phi = 33'(th);
    end else if (cz_item.px[31] && !cz_item.py[31]) begin
      phi = (33'd1 << 31) - 33'(th);
    end else if (cz_item.px[31]) begin
      phi = (33'd1 << 31) + 33'(th);
    end else begin
      phi = (33'd1 << 32) - 33'(th);
    end
    phi_rnd = phi + 33'd32768;
  end

  always_comb begin
    sz_item_next      = cz_item;
    sz_item_next.code = phi_rnd[32:16];
    sz_item_next.miss = cz_item.miss || (phi_rnd[32:16] > phi_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sz_valid <= 1'b0;
    end else begin
      sz_valid <= cz_valid;
    end
    sz_item <= sz_item_next;
  end

  // u = code * 65536 / phi_limit
  logic           uq_valid;
  logic [16:0]    uq;
  rdi_pkg::item_t uq_item;
  rdi_pkg::item_t sq_in;

  rdi_div #(
    .NW(33), .DW(17), .QW(rdi_pkg::PART_QW), .SW($bits(rdi_pkg::item_t))
  ) u_div_u (
    .clk(clk), .rst(rst), .in_valid(sz_valid), .num({sz_item.code, 16'd0}),
    .den(phi_limit), .side_in(sz_item), .out_valid(uq_valid), .quo(uq),
    .side_out(uq_item)
  );

  always_comb begin
    sq_in   = uq_item;
    sq_in.u = uq;
  end

  // Integer square root of the squared radius, one result bit per stage
  logic           sq_valid [NQ];
  logic [63:0]    sq_n     [NQ];
  logic [63:0]    sq_res   [NQ];
  rdi_pkg::item_t sq_item  [NQ];

  genvar k;
  for (k = 0; k < NQ; k++) begin : g_sqrt
    logic           vi;
    logic [63:0]    ni;
    logic [63:0]    ri;
    logic [63:0]    trial;
    logic [63:0]    no;
    logic [63:0]    ro;
    rdi_pkg::item_t ii;

    if (k == 0) begin : g_first
      assign vi = uq_valid;
      assign ni = 64'(uq_item.d2);
      assign ri = '0;
      assign ii = sq_in;
    end else begin : g_next
      assign vi = sq_valid[k-1];
      assign ni = sq_n[k-1];
      assign ri = sq_res[k-1];
      assign ii = sq_item[k-1];
    end

    always_comb begin
      trial = ri + (64'd1 << (62 - 2 * k));
      if (ni >= trial) begin
        no = ni - trial;
        ro = (ri >> 1) + (64'd1 << (62 - 2 * k));
      end else begin
        no = ni;
        ro = ri >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k] <= 1'b0;
      end else begin
        sq_valid[k] <= vi;
      end
      sq_n[k]    <= no;
      sq_res[k]  <= ro;
      sq_item[k] <= ii;
    end
  end

  // Stage V: radial distance from the outer edge
  logic [31:0]    rdiff;
  logic           sv_valid;
  logic [46:0]    sv_num;
  logic [30:0]    sv_den;
  rdi_pkg::item_t sv_item;

  assign rdiff = 32'(outer_radius) - sq_res[NQ-1][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv_valid <= 1'b0;
    end else begin
      sv_valid <= sq_valid[NQ-1];
    end
    sv_num  <= {rdiff[30:0], 16'd0};
    sv_den  <= outer_radius - inner_radius;
    sv_item <= sq_item[NQ-1];
  end

  // v = (outer - r) * 65536 / (outer - inner)
  logic           vq_valid;
  logic [16:0]    vq;
  rdi_pkg::item_t vq_item;

  rdi_div #(
    .NW(47), .DW(31), .QW(rdi_pkg::PART_QW), .SW($bits(rdi_pkg::item_t))
  ) u_div_v (
    .clk(clk), .rst(rst), .in_valid(sv_valid), .num(sv_num), .den(sv_den),
    .side_in(sv_item), .out_valid(vq_valid), .quo(vq), .side_out(vq_item)
  );

  // Output register: saturate, zero the fields on a miss, zero u or v when its divisor is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq_valid;
    end
    hit   <= vq_valid && !vq_item.miss;
    t_hit <= vq_item.miss ? '0 : vq_item.t;
    hit_x <= vq_item.miss ? '0 : vq_item.px;
    hit_y <= vq_item.miss ? '0 : vq_item.py;
    if (vq_item.miss || (phi_limit == '0)) begin
      param_u <= '0;
    end else begin
      param_u <= vq_item.u[16] ? 16'hFFFF : vq_item.u[15:0];
    end
    if (vq_item.miss || (outer_radius == inner_radius)) begin
      param_v <= '0;
    end else begin
      param_v <= vq[16] ? 16'hFFFF : vq[15:0];
    end
  end

  // Every accepted ray comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result strobe missing after pipeline latency");

  // A hit is only reported together with its strobe
  a_hit_strobe: assert property (@(posedge clk) disable iff (rst)
    hit |-> done)
    else $error("hit without result strobe");

  // A delivered miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (t_hit == '0) && (hit_x == '0) && (hit_y == '0)
                       && (param_u == '0) && (param_v == '0))
    else $error("miss result with nonzero fields");

endmodule
